// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/gts_pkg.sv
package gts_pkg;

    localparam int DIM_WIDTH_DEF = 16;
    localparam int MS_W          = 13;
    localparam int TM_W          = 18;
    localparam int TN_W          = 13;
    localparam int TK_W          = 18;
    localparam int M_TDATA_W     = ((TM_W + TN_W + TK_W + 7) / 8) * 8;

    localparam logic [MS_W-1:0] MS_RESET = 13'd256;

    // divider operand selection
    localparam logic [1:0] DIV_MS_TN   = 2'd0;
    localparam logic [1:0] DIV_MS_PROD = 2'd1;
    localparam logic [1:0] DIV_N_TN    = 2'd2;
    localparam logic [1:0] DIV_N_HALF  = 2'd3;

    typedef struct packed {
        logic       load_in;
        logic       prep;
        logic       div_start;
        logic [1:0] div_sel;
        logic       take_tk;
        logic       mul;
        logic       take_tm;
        logic       take_r;
        logic       take_rh;
        logic       rh_from_div;
        logic       halve;
        logic       phase;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic tn_even;
        logic tn_ge2;
        logic loop_go;
        logic helps;
    } sts_t;

endpackage

// File: rtl/core/gemm_tile_size_selector_top.sv
// GEMM tile size selector.
// Input transaction on s_*: dim_m, dim_n, dim_k packed in s_tdata.
// Result transaction on m_*: tile_m, tile_n, tile_k packed in m_tdata.
// cfg_we/cfg_wdata write ms_count (multiplier count), reset value 256.
// One transaction is processed at a time; s_tready is high only while idle,
// so the next transaction can be taken in the same cycle that m_tvalid rises.
// After accept the controller prepares the initial tiles, runs the two
// budget divisions and the remainder of dim_n by tile_n, then halves tile_n
// in two phases: an even tile_n halves without a division, an odd one waits
// for the divider (at most 12 halving steps); a phase ends when a probe finds no gain or the loop cannot go on.
// The shared one-bit-per-cycle divider serves the two budget divisions and
// the remainders of dim_n by tile_n and by half of tile_n.
// The result sits in an output register; a new input is accepted while it
// waits. If the receiver stalls, the next result holds in the datapath
// until the output register frees, and no input is taken meanwhile.
// aresetn (synchronous, active low) returns the controller to idle, drops
// m_tvalid and restores ms_count to 256.
module gemm_tile_size_selector_top #(
    parameter int DIM_WIDTH = gts_pkg::DIM_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [gts_pkg::MS_W-1:0]          cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((3*DIM_WIDTH+7)/8)*8-1:0]  s_tdata,   // dim_m, dim_n, dim_k
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gts_pkg::M_TDATA_W-1:0]     m_tdata    // tile_m, tile_n, tile_k
);

    localparam int DW    = DIM_WIDTH;
    localparam int OUT_W = gts_pkg::TM_W + gts_pkg::TN_W + gts_pkg::TK_W;

    gts_pkg::cmd_t cmd;
    gts_pkg::sts_t sts;

    logic [DW-1:0]               dim_m, dim_n, dim_k;
    logic [gts_pkg::TM_W-1:0]    tile_m;
    logic [gts_pkg::TN_W-1:0]    tile_n;
    logic [gts_pkg::TK_W-1:0]    tile_k;

    assign dim_m = s_tdata[DW-1:0];
    assign dim_n = s_tdata[2*DW-1:DW];
    assign dim_k = s_tdata[3*DW-1:2*DW];

    assign m_tdata = gts_pkg::M_TDATA_W'({tile_k, tile_n, tile_m});

    gts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    gts_datapath #(
        .DIM_WIDTH(DIM_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .dim_m     (dim_m),
        .dim_n     (dim_n),
        .dim_k     (dim_k),
        .cmd       (cmd),
        .sts       (sts),
        .tile_m    (tile_m),
        .tile_n    (tile_n),
        .tile_k    (tile_k)
    );

    if (OUT_W > gts_pkg::M_TDATA_W) begin : g_width_check
        $error("result fields exceed m_tdata");
    end

endmodule

// File: rtl/core/gts_div.sv
module gts_div #(
    parameter int DVW = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DVW-1:0]           dividend,
    input  logic [gts_pkg::MS_W-1:0] divisor,
    output logic                     done,
    output logic [DVW-1:0]           quot,
    output logic [gts_pkg::MS_W-1:0] rem
);

    localparam int CNT_W = $clog2(DVW);
    localparam int MW    = gts_pkg::MS_W;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVW-1:0]   quot_reg;
    logic [MW-1:0]    rem_reg;
    logic [MW-1:0]    dsr_reg;

    logic [MW:0]      trial;
    logic [MW:0]      diff;
    logic             ge;
    logic [MW-1:0]    rem_next;
    logic [DVW-1:0]   quot_next;

    assign trial     = {rem_reg, quot_reg[DVW-1]};
    assign diff      = trial - {1'b0, dsr_reg};
    assign ge        = (trial >= {1'b0, dsr_reg});
    assign rem_next  = ge ? diff[MW-1:0] : trial[MW-1:0];
    assign quot_next = {quot_reg[DVW-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/core/gts_datapath.sv
module gts_datapath #(
    parameter int DIM_WIDTH = gts_pkg::DIM_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [gts_pkg::MS_W-1:0] cfg_wdata,
    input  logic [DIM_WIDTH-1:0]     dim_m,
    input  logic [DIM_WIDTH-1:0]     dim_n,
    input  logic [DIM_WIDTH-1:0]     dim_k,
    input  gts_pkg::cmd_t            cmd,
    output gts_pkg::sts_t            sts,
    output logic [gts_pkg::TM_W-1:0] tile_m,
    output logic [gts_pkg::TN_W-1:0] tile_n,
    output logic [gts_pkg::TK_W-1:0] tile_k
);

    localparam int DW  = DIM_WIDTH;
    localparam int MW  = gts_pkg::MS_W;
    localparam int TW  = DW + 1;
    localparam int DVW = (DW > MW) ? DW : MW;
    localparam int EW  = (TW > DVW) ? TW : DVW;
    localparam int CW  = (DW > MW + 2) ? DW : MW + 2;

    logic [MW-1:0] ms_reg;
    logic [DW-1:0] m_reg, n_reg, k_reg;
    logic [TW-1:0] pk_reg, pm_reg;
    logic [TW-1:0] tk_reg, tm_reg;
    logic [MW-1:0] tn_reg, prod_reg, r_reg, rh_reg;
    logic [gts_pkg::TM_W-1:0] tile_m_reg;
    logic [gts_pkg::TN_W-1:0] tile_n_reg;
    logic [gts_pkg::TK_W-1:0] tile_k_reg;

    logic           div_start;
    logic [DVW-1:0] div_dividend;
    logic [MW-1:0]  div_divisor;
    logic           div_done;
    logic [DVW-1:0] div_quot;
    logic [MW-1:0]  div_rem;

    logic [TW-1:0]     pn;
    logic [MW-1:0]     budget;
    logic [MW-1:0]     tn_next;
    logic [TW-1:0]     tile_min;
    logic [TW-1:0]     tk_next, tm_next;
    logic [2*MW-1:0]   prod_full;
    logic [MW-1:0]     half;
    logic [MW-1:0]     rh_fast;
    logic [MW-1:0]     pad_full, pad_half;
    logic              under;

    function automatic logic [TW-1:0] pow2_ceil(input logic [DW-1:0] x);
        logic [DW-1:0] s;
        s = x - 1'b1;
        for (int i = 0; i < 6; i++) begin
            if ((2 ** i) < DW) begin
                s = s | (s >> (2 ** i));
            end
        end
        if (x == '0) begin
            return TW'(1);
        end
        return {1'b0, s} + 1'b1;
    endfunction

    // ---- operand selection and shared divider
    assign div_start = cmd.div_start;
    assign half      = tn_reg >> 1;

    always_comb begin
        div_dividend = DVW'(ms_reg);
        div_divisor  = tn_reg;
        unique case (cmd.div_sel)
            gts_pkg::DIV_MS_TN: begin
                div_dividend = DVW'(ms_reg);
                div_divisor  = tn_reg;
            end
            gts_pkg::DIV_MS_PROD: begin
                div_dividend = DVW'(ms_reg);
                div_divisor  = prod_reg;
            end
            gts_pkg::DIV_N_TN: begin
                div_dividend = DVW'(n_reg);
                div_divisor  = tn_reg;
            end
            gts_pkg::DIV_N_HALF: begin
                div_dividend = DVW'(n_reg);
                div_divisor  = half;
            end
            default: begin
                div_dividend = DVW'(ms_reg);
                div_divisor  = tn_reg;
            end
        endcase
    end

    gts_div #(
        .DVW(DVW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // ---- initial tiles
    assign pn     = pow2_ceil(n_reg);
    assign budget = (k_reg > DW'(1)) ? (ms_reg >> 1) : ms_reg;

    always_comb begin
        if (EW'(pn) < EW'(budget)) begin
            tn_next = MW'(pn);
        end else begin
            tn_next = budget;
        end
        if (tn_next == '0) begin
            tn_next = MW'(1);
        end
    end

    always_comb begin
        logic [TW-1:0] pick;
        pick = cmd.take_tm ? pm_reg : pk_reg;
        if (EW'(pick) < EW'(div_quot)) begin
            tile_min = pick;
        end else begin
            tile_min = TW'(div_quot);
        end
        if (tile_min == '0) begin
            tile_min = TW'(1);
        end
    end

    assign prod_full = tn_reg * MW'(tk_reg);

    // ---- halving loop terms
    assign rh_fast  = (r_reg >= half) ? (r_reg - half) : r_reg;
    assign pad_full = (r_reg == '0) ? '0 : (tn_reg - r_reg);
    assign pad_half = (rh_reg == '0) ? '0 : (half - rh_reg);
    assign under    = CW'(n_reg) < CW'({pad_full, 2'b00});

    assign tk_next = (cmd.halve && !cmd.phase) ? (tk_reg << 1) : tile_min;
    assign tm_next = (cmd.halve && cmd.phase) ? (tm_reg << 1) : tile_min;

    assign sts.div_done = div_done;
    assign sts.tn_even  = ~tn_reg[0];
    assign sts.tn_ge2   = (tn_reg >= MW'(2));
    assign sts.loop_go  = under && (cmd.phase ? (tm_reg <= TW'(m_reg))
                                              : (tk_reg <= TW'(k_reg)));
    assign sts.helps    = (pad_full != pad_half);

    // ---- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_reg <= gts_pkg::MS_RESET;
        end else if (cfg_we) begin
            ms_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            m_reg <= dim_m;
            n_reg <= dim_n;
            k_reg <= dim_k;
        end
        if (cmd.prep) begin
            pk_reg <= pow2_ceil(k_reg);
            pm_reg <= pow2_ceil(m_reg);
            tn_reg <= tn_next;
        end else if (cmd.halve) begin
            tn_reg <= half;
        end
        if (cmd.take_tk || (cmd.halve && !cmd.phase)) begin
            tk_reg <= tk_next;
        end
        if (cmd.take_tm || (cmd.halve && cmd.phase)) begin
            tm_reg <= tm_next;
        end
        if (cmd.mul) begin
            prod_reg <= prod_full[MW-1:0];
        end
        if (cmd.take_r) begin
            r_reg <= div_rem;
        end else if (cmd.halve) begin
            r_reg <= rh_reg;
        end
        if (cmd.take_rh) begin
            rh_reg <= cmd.rh_from_div ? div_rem : rh_fast;
        end
        if (cmd.load_out) begin
            tile_m_reg <= gts_pkg::TM_W'(tm_reg);
            tile_n_reg <= gts_pkg::TN_W'(tn_reg);
            tile_k_reg <= gts_pkg::TK_W'(tk_reg);
        end
    end

    assign tile_m = tile_m_reg;
    assign tile_n = tile_n_reg;
    assign tile_k = tile_k_reg;

endmodule

// File: rtl/core/gts_ctrl.sv
`include "assert_macros.svh"

module gts_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output gts_pkg::cmd_t cmd,
    input  gts_pkg::sts_t sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_ST_TK = 4'd2;
    localparam logic [3:0] S_W_TK  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_ST_TM = 4'd5;
    localparam logic [3:0] S_W_TM  = 4'd6;
    localparam logic [3:0] S_ST_R  = 4'd7;
    localparam logic [3:0] S_W_R   = 4'd8;
    localparam logic [3:0] S_LOOP  = 4'd9;
    localparam logic [3:0] S_W_RH  = 4'd10;
    localparam logic [3:0] S_HALF  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       phase_reg, phase_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        cmd.phase    = phase_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    phase_next  = 1'b0;
                    state_next  = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_ST_TK;
            end
            S_ST_TK: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = gts_pkg::DIV_MS_TN;
                state_next    = S_W_TK;
            end
            S_W_TK: begin
                if (sts.div_done) begin
                    cmd.take_tk = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ST_TM;
            end
            S_ST_TM: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = gts_pkg::DIV_MS_PROD;
                state_next    = S_W_TM;
            end
            S_W_TM: begin
                if (sts.div_done) begin
                    cmd.take_tm = 1'b1;
                    state_next  = S_ST_R;
                end
            end
            S_ST_R: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = gts_pkg::DIV_N_TN;
                state_next    = S_W_R;
            end
            S_W_R: begin
                if (sts.div_done) begin
                    cmd.take_r = 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (sts.loop_go && sts.tn_ge2) begin
                    if (sts.tn_even) begin
                        cmd.take_rh = 1'b1;
                        state_next  = S_HALF;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = gts_pkg::DIV_N_HALF;
                        state_next    = S_W_RH;
                    end
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_W_RH: begin
                if (sts.div_done) begin
                    cmd.take_rh     = 1'b1;
                    cmd.rh_from_div = 1'b1;
                    state_next      = S_HALF;
                end
            end
            S_HALF: begin
                if (sts.helps) begin
                    cmd.halve  = 1'b1;
                    state_next = S_LOOP;
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                    state_next = S_LOOP;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_ALL(a_reset_idle, aclk, !aresetn |=> (state_reg == S_IDLE) && !m_valid_reg, "reset did not clear controller")
    `ASSERT_RST(a_accept_prep, aclk, aresetn, s_tvalid && s_tready |=> state_reg == S_PREP, "accepted transaction did not start")
    `ASSERT_RST(a_done_waiting, aclk, aresetn, sts.div_done |-> (state_reg == S_W_TK) || (state_reg == S_W_TM) || (state_reg == S_W_R) || (state_reg == S_W_RH), "divider finished outside a wait state")
    `ASSERT_RST(a_valid_from_done, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg) == S_DONE, "result raised without a finished transaction")

endmodule
